// File: rtl/bdlp_pkg.sv
package bdlp_pkg;

   localparam int NUM_BUTTONS_DEFAULT = 3;

   // Fixed field widths of the request and response items.
   localparam int OP_W      = 2;
   localparam int PINS_W    = 3;
   localparam int INDEX_W   = 2;
   localparam int EVENT_W   = 2;
   localparam int PENDING_W = 6;
   localparam int REPORTED_BUTTONS = PENDING_W / EVENT_W;

   localparam int DEBOUNCE_W  = 8;
   localparam int LONG_W      = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [OP_W-1:0] OP_TICK        = 2'd0;
   localparam logic [OP_W-1:0] OP_QUERY_SHORT = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY_LONG  = 2'd2;

   localparam logic [EVENT_W-1:0] EVENT_NONE  = 2'd0;
   localparam logic [EVENT_W-1:0] EVENT_SHORT = 2'd1;
   localparam logic [EVENT_W-1:0] EVENT_LONG  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_TICKS   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_PRESS_TICKS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESSED_LEVEL    = 2'd2;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 8'd10;
   localparam logic [LONG_W-1:0]     LONG_RESET     = 16'd100;
   localparam logic                  LEVEL_RESET    = 1'b0;

   typedef struct packed {
      logic [DEBOUNCE_W-1:0] debounce_ticks;
      logic [LONG_W-1:0]     long_press_ticks;
      logic                  pressed_level;
   } cfg_type;

   typedef struct packed {
      logic               hit;
      logic [EVENT_W-1:0] event_next;
   } lane_result_type;

endpackage

// File: rtl/bdlp_lane.sv
module bdlp_lane (
   input  logic                       clock,
   input  logic                       reset,
   input  bdlp_pkg::cfg_type          cfg,
   input  logic                       tick_en,
   input  logic                       level,
   input  logic                       query_en,
   input  logic                       query_long,
   output bdlp_pkg::lane_result_type  result
);

   typedef enum logic [1:0] {
      MODE_IDLE     = 2'd0,
      MODE_DEBOUNCE = 2'd1,
      MODE_PRESSED  = 2'd2,
      MODE_LONG     = 2'd3
   } mode_type;

   mode_type                            mode_ff, mode_in;
   logic [bdlp_pkg::LONG_W-1:0]         count_ff, count_in;
   logic [bdlp_pkg::EVENT_W-1:0]        event_ff, event_in;
   logic                                newest_ff, newest_in;
   logic                                middle_ff, middle_in;
   logic                                oldest_ff, oldest_in;
   logic                                hit;
   logic                                pr;

   assign pr = cfg.pressed_level;

   always_comb begin
      mode_in   = mode_ff;
      count_in  = count_ff;
      event_in  = event_ff;
      newest_in = newest_ff;
      middle_in = middle_ff;
      oldest_in = oldest_ff;
      hit       = 1'b0;
      if (tick_en) begin
         oldest_in = middle_ff;
         middle_in = newest_ff;
         newest_in = level;
         case (mode_ff)
            MODE_IDLE: begin
               if (newest_in == pr && middle_in == pr && oldest_in == pr) begin
                  mode_in  = MODE_DEBOUNCE;
                  count_in = {{(bdlp_pkg::LONG_W-bdlp_pkg::DEBOUNCE_W){1'b0}},
                              cfg.debounce_ticks};
               end
            end
            MODE_DEBOUNCE: begin
               if (count_ff != '0) begin
                  count_in = count_ff - 1'b1;
               end else if (level == pr) begin
                  mode_in  = MODE_PRESSED;
                  count_in = cfg.long_press_ticks;
                  event_in = bdlp_pkg::EVENT_SHORT;
               end else begin
                  mode_in = MODE_IDLE;
               end
            end
            MODE_PRESSED: begin
               // Release wins over the long-press countdown.
               if (level != pr) begin
                  mode_in = MODE_IDLE;
               end else if (count_ff != '0) begin
                  count_in = count_ff - 1'b1;
               end else begin
                  mode_in  = MODE_LONG;
                  event_in = bdlp_pkg::EVENT_LONG;
               end
            end
            MODE_LONG: begin
               if (level != pr) begin
                  mode_in = MODE_IDLE;
               end else begin
                  event_in = bdlp_pkg::EVENT_LONG;
                  count_in = cfg.long_press_ticks;
               end
            end
            default: begin
               mode_in = MODE_IDLE;
            end
         endcase
      end else if (query_en) begin
         if ((!query_long && event_ff == bdlp_pkg::EVENT_SHORT) ||
             (query_long && event_ff == bdlp_pkg::EVENT_LONG)) begin
            event_in = bdlp_pkg::EVENT_NONE;
            hit      = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         count_ff  <= '0;
         event_ff  <= bdlp_pkg::EVENT_NONE;
         // Released level after reset is the complement of the reset pressed level.
         newest_ff <= ~bdlp_pkg::LEVEL_RESET;
         middle_ff <= ~bdlp_pkg::LEVEL_RESET;
         oldest_ff <= ~bdlp_pkg::LEVEL_RESET;
      end else begin
         mode_ff   <= mode_in;
         count_ff  <= count_in;
         event_ff  <= event_in;
         newest_ff <= newest_in;
         middle_ff <= middle_in;
         oldest_ff <= oldest_in;
      end
   end

   assign result.hit        = hit;
   assign result.event_next = event_in;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      (tick_en && mode_ff == MODE_DEBOUNCE && count_ff != '0)
      |=> (mode_ff == MODE_DEBOUNCE && count_ff == $past(count_ff) - 1'b1))
      else $error("debounce countdown did not step down by one");

   assert property (@(posedge clock) disable iff (reset)
      (tick_en && mode_ff == MODE_DEBOUNCE && count_ff == '0 && level == pr)
      |=> (mode_ff == MODE_PRESSED && event_ff == bdlp_pkg::EVENT_SHORT))
      else $error("confirmed press did not raise a short event");

   assert property (@(posedge clock) disable iff (reset)
      hit |=> (event_ff == bdlp_pkg::EVENT_NONE))
      else $error("event not cleared after a query hit");

   assert property (@(posedge clock) disable iff (reset)
      (!tick_en && !query_en) |=> $stable(mode_ff) && $stable(event_ff))
      else $error("button state changed without a request");
`endif

endmodule

// File: rtl/bdlp_merge.sv
module bdlp_merge #(
   parameter int NUM_BUTTONS = bdlp_pkg::NUM_BUTTONS_DEFAULT
) (
   input  bdlp_pkg::lane_result_type           lane_result [NUM_BUTTONS],
   output logic                                query_hit,
   output logic [bdlp_pkg::PENDING_W-1:0]      pending_events
);

   logic [NUM_BUTTONS-1:0] hits;

   for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_hit
      assign hits[i] = lane_result[i].hit;
   end

   // At most one lane is addressed by a query, so an OR merges the hits.
   assign query_hit = |hits;

   for (genvar k = 0; k < bdlp_pkg::REPORTED_BUTTONS; k++) begin : g_pack
      if (k < NUM_BUTTONS) begin : g_lane
         assign pending_events[bdlp_pkg::EVENT_W*k +: bdlp_pkg::EVENT_W] =
            lane_result[k].event_next;
      end else begin : g_absent
         assign pending_events[bdlp_pkg::EVENT_W*k +: bdlp_pkg::EVENT_W] = '0;
      end
   end

endmodule

// File: rtl/button_debounce_long_press.sv
// Each response is written into the response buffer when its request is accepted.
// Throughput: one request per cycle unless the response buffer is full; a tick updates every button lane.
// A two-entry response buffer keeps requests flowing while a response waits.
// Configuration writes are taken in any cycle, one per cycle.
// Reset (synchronous, active high) restores register defaults, idles all buttons,
// fills the sample stages with the released level and empties the response buffer.
module button_debounce_long_press #(
   parameter int NUM_BUTTONS = bdlp_pkg::NUM_BUTTONS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,  // pin_levels[2:0], button_index[4:3]
   input  logic [bdlp_pkg::OP_W-1:0]          req_tuser,  // operation[1:0]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [7:0]                         rsp_tdata,  // query_hit[0], pending_events[6:1]
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bdlp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bdlp_pkg::CSR_DATA_W-1:0]    csr_data
);

   typedef struct packed {
      logic                              hit;
      logic [bdlp_pkg::PENDING_W-1:0]    pending;
   } rsp_entry_type;

   bdlp_pkg::cfg_type                 cfg_ff;
   bdlp_pkg::lane_result_type         lane_result [NUM_BUTTONS];
   rsp_entry_type                     buf_ff [2];
   logic                              wr_ptr_ff, rd_ptr_ff;
   logic [1:0]                        count_ff;
   logic                              push, pop;
   logic                              tick_en, query_en, query_long;
   logic [bdlp_pkg::OP_W-1:0]         op;
   logic [bdlp_pkg::PINS_W-1:0]       pins;
   logic [bdlp_pkg::INDEX_W-1:0]      idx;
   logic                              merged_hit;
   logic [bdlp_pkg::PENDING_W-1:0]    merged_pending;

   assign op   = req_tuser;
   assign pins = req_tdata[2:0];
   assign idx  = req_tdata[4:3];

   assign req_tready = ~count_ff[1];
   assign push       = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;

   assign tick_en    = push && op == bdlp_pkg::OP_TICK;
   assign query_en   = push && (op == bdlp_pkg::OP_QUERY_SHORT ||
                                op == bdlp_pkg::OP_QUERY_LONG);
   assign query_long = op == bdlp_pkg::OP_QUERY_LONG;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks   <= bdlp_pkg::DEBOUNCE_RESET;
         cfg_ff.long_press_ticks <= bdlp_pkg::LONG_RESET;
         cfg_ff.pressed_level    <= bdlp_pkg::LEVEL_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            bdlp_pkg::CSR_DEBOUNCE_TICKS:
               cfg_ff.debounce_ticks <= csr_data[bdlp_pkg::DEBOUNCE_W-1:0];
            bdlp_pkg::CSR_LONG_PRESS_TICKS:
               cfg_ff.long_press_ticks <= csr_data[bdlp_pkg::LONG_W-1:0];
            bdlp_pkg::CSR_PRESSED_LEVEL:
               cfg_ff.pressed_level <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
      logic lane_level;
      logic lane_query;

      if (i < bdlp_pkg::PINS_W) begin : g_pin
         assign lane_level = pins[i];
      end else begin : g_nopin
         assign lane_level = 1'b0;
      end

      assign lane_query = query_en && (32'(idx) == i);

      bdlp_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .cfg        (cfg_ff),
         .tick_en    (tick_en),
         .level      (lane_level),
         .query_en   (lane_query),
         .query_long (query_long),
         .result     (lane_result[i])
      );
   end

   bdlp_merge #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_merge (
      .lane_result    (lane_result),
      .query_hit      (merged_hit),
      .pending_events (merged_pending)
   );

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff].hit     <= merged_hit;
         buf_ff[wr_ptr_ff].pending <= merged_pending;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   assign rsp_tvalid = count_ff != 2'd0;
   assign rsp_tdata  = {1'b0, buf_ff[rd_ptr_ff].pending, buf_ff[rd_ptr_ff].hit};

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("response buffer lost a pushed response");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("pending response dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2) |-> !req_tready)
      else $error("request taken while response buffer full");
`endif

endmodule
